@@ hw/rtl/bsd_pkg.sv @@
// ============================================================================
// bsd_pkg: shared constants and types for the block-scaled dot product
// Element packing, lane split, fixed-point alignment and pipeline control.
// ============================================================================
package bsd_pkg;

  localparam int BLOCK_SIZE      = 32;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int ACC_WIDTH       = 64;

  localparam int OUT_FRAC_BITS = 32;
  localparam int CARRIED_ELEMS = 32;

  localparam int LANES      = 4;
  localparam int LANE_ELEMS = CARRIED_ELEMS / LANES;
  localparam int LANE_IDX_W = $clog2(LANES);

  localparam int ACT_W   = 8;
  localparam int WT_W    = 4;
  localparam int SCALE_W = 16;
  localparam int WORD_W  = 64;
  localparam int SUM_W   = 64;
  localparam int TERM_W  = 64;

  localparam int PROD_W = ACT_W + WT_W;
  localparam int PART_W = PROD_W + $clog2(LANE_ELEMS);
  localparam int DOT_W  = PART_W + $clog2(LANES);
  localparam int MAG_W  = DOT_W - 1;
  localparam int MUL1_W = MAG_W + SCALE_W;
  localparam int MUL2_W = MUL1_W + SCALE_W;

  // Alignment of the 2*SCALE_FRAC_BITS product to OUT_FRAC_BITS fraction bits.
  localparam int SHL = (2 * SCALE_FRAC_BITS < OUT_FRAC_BITS) ?
                       (OUT_FRAC_BITS - 2 * SCALE_FRAC_BITS) : 0;
  localparam int SHR = (2 * SCALE_FRAC_BITS > OUT_FRAC_BITS) ?
                       (2 * SCALE_FRAC_BITS - OUT_FRAC_BITS) : 0;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  // Elements past the configured block size contribute nothing.
  function automatic logic [LANE_ELEMS-1:0] elem_enable(input logic [LANE_IDX_W-1:0] lane);
    logic [LANE_ELEMS-1:0] en;
    int                    idx;
    for (int e = 0; e < LANE_ELEMS; e++) begin
      idx   = int'(lane) * LANE_ELEMS + e;
      en[e] = (idx < BLOCK_SIZE);
    end
    return en;
  endfunction

endpackage

@@ hw/rtl/bsd_lane.sv @@
// ============================================================================
// bsd_lane: partial dot product of one lane
// Multiplies eight signed bytes by eight signed nibbles and registers the sum.
// ============================================================================
module bsd_lane (
  input  logic                                          clk,
  input  logic                                          adv,
  input  logic [bsd_pkg::LANE_ELEMS*bsd_pkg::ACT_W-1:0] act_word,
  input  logic [bsd_pkg::LANE_ELEMS*bsd_pkg::WT_W-1:0]  wt_word,
  input  logic [bsd_pkg::LANE_ELEMS-1:0]                elem_en,
  output logic signed [bsd_pkg::PART_W-1:0]             partial
);
  import bsd_pkg::*;

  logic signed [PART_W-1:0] partial_next;

  always_comb begin
    logic signed [ACT_W-1:0]  a;
    logic signed [WT_W-1:0]   w;
    logic signed [PROD_W-1:0] p;
    partial_next = '0;
    for (int e = 0; e < LANE_ELEMS; e++) begin
      a = act_word[e*ACT_W +: ACT_W];
      w = wt_word[e*WT_W +: WT_W];
      p = PROD_W'(a) * PROD_W'(w);
      if (elem_en[e]) begin
        partial_next = partial_next + PART_W'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      partial <= partial_next;
    end
  end

endmodule

@@ hw/rtl/bsd_scale.sv @@
// ============================================================================
// bsd_scale: scale the block dot product
// Two registered multiplies by the scales, then alignment to the output format.
// ============================================================================
module bsd_scale (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  bsd_pkg::stage_ctl_t                  ctl_in,
  input  logic signed [bsd_pkg::DOT_W-1:0]     dot,
  input  logic [bsd_pkg::SCALE_W-1:0]          act_scale,
  input  logic [bsd_pkg::SCALE_W-1:0]          weight_scale,
  output bsd_pkg::stage_ctl_t                  ctl_out,
  output logic signed [bsd_pkg::TERM_W-1:0]    term
);
  import bsd_pkg::*;

  localparam logic [TERM_W-1:0] RND = (TERM_W'(1) << SHR) - TERM_W'(1);

  stage_ctl_t          ctl_m1, ctl_m2;
  logic                neg_m1, neg_m2;
  logic [SCALE_W-1:0]  ws_m1;
  logic [MUL1_W-1:0]   prod1;
  logic [MUL2_W-1:0]   prod2;

  logic [DOT_W-1:0]    mag_full;
  logic [MAG_W-1:0]    mag;
  logic [TERM_W-1:0]   aligned;

  // The magnitude of the most negative dot still fits in MAG_W bits.
  assign mag_full = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
  assign mag      = mag_full[MAG_W-1:0];

  // Rounding up the magnitude of a negative term gives an arithmetic shift.
  assign aligned = ((TERM_W'(prod2) + (neg_m2 ? RND : '0)) >> SHR) << SHL;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_m1  <= '0;
      ctl_m2  <= '0;
      ctl_out <= '0;
    end else if (adv) begin
      ctl_m1  <= ctl_in;
      ctl_m2  <= ctl_m1;
      ctl_out <= ctl_m2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_m1 <= dot[DOT_W-1];
      ws_m1  <= weight_scale;
      prod1  <= MUL1_W'(mag) * MUL1_W'(act_scale);
      neg_m2 <= neg_m1;
      prod2  <= MUL2_W'(prod1) * MUL2_W'(ws_m1);
      term   <= neg_m2 ? -$signed(aligned) : $signed(aligned);
    end
  end

endmodule

@@ hw/rtl/bsd_accum.sv @@
// ============================================================================
// bsd_accum: saturating accumulator and result register
// Adds each block term, clamps at the accumulator bounds, emits on last block.
// ============================================================================
module bsd_accum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  bsd_pkg::stage_ctl_t                 ctl,
  input  logic signed [bsd_pkg::TERM_W-1:0]   term,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [bsd_pkg::SUM_W-1:0]    scaled_sum,
  output logic                                overflowed
);
  import bsd_pkg::*;

  localparam int EXT_W = TERM_W + 1;
  localparam logic signed [EXT_W-1:0] ACC_MAX = (EXT_W'(1) <<< (ACC_WIDTH - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] ACC_MIN = -ACC_MAX - EXT_W'(1);

  logic signed [ACC_WIDTH-1:0] acc;
  logic                        sat;

  logic signed [EXT_W-1:0]     sum;
  logic signed [ACC_WIDTH-1:0] acc_next;
  logic                        sat_next;

  always_comb begin
    sum = EXT_W'(acc) + EXT_W'(term);
    if (sum > ACC_MAX) begin
      acc_next = ACC_WIDTH'(ACC_MAX);
      sat_next = 1'b1;
    end else if (sum < ACC_MIN) begin
      acc_next = ACC_WIDTH'(ACC_MIN);
      sat_next = 1'b1;
    end else begin
      acc_next = ACC_WIDTH'(sum);
      sat_next = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      // adv implies any pending result has just been taken.
      out_valid <= 1'b0;
      if (ctl.valid) begin
        if (ctl.last) begin
          out_valid  <= 1'b1;
          scaled_sum <= SUM_W'(acc_next);
          overflowed <= sat_next;
          acc        <= '0;
          sat        <= 1'b0;
        end else begin
          acc <= acc_next;
          sat <= sat_next;
        end
      end
    end
  end

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (adv && ctl.valid && ctl.last) |=> (acc == '0 && !sat && out_valid))
    else $error("accumulator not cleared after a last block");

  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    (sat && !(adv && ctl.valid && ctl.last)) |=> sat)
    else $error("saturation flag dropped within a dot product");

  a_result_retires: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !(ctl.valid && ctl.last)) |=> !out_valid)
    else $error("result beat repeated after it was taken");

  a_stall_holds_acc: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(acc) && $stable(sat)))
    else $error("accumulator changed while the pipeline was stalled");

endmodule

@@ hw/rtl/int4_int8_block_scaled_dot.sv @@
// ============================================================================
// int4_int8_block_scaled_dot: block-quantized int8 x int4 dot product
// Four lanes, a merge stage, scale multiplies and a saturating accumulator.
// ============================================================================
// Takes one 32-element block beat per clock while in_ready is high, and passes
// each accepted block through lane products, lane merge, two scale multiplies,
// alignment, and the saturating accumulate that loads the result
// register. The accumulate stage's single 65-bit add and clamp closes the loop
// between successive blocks, so blocks of one dot product stream back to back.
// A result beat appears only for a block marked last; it carries the sum with
// 32 fraction bits and a flag that the accumulator clamped during that dot
// product. While a result waits, the whole pipeline holds and in_ready is low.
module int4_int8_block_scaled_dot (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bsd_pkg::WORD_W-1:0]         act_bytes_0,
  input  logic [bsd_pkg::WORD_W-1:0]         act_bytes_1,
  input  logic [bsd_pkg::WORD_W-1:0]         act_bytes_2,
  input  logic [bsd_pkg::WORD_W-1:0]         act_bytes_3,
  input  logic [bsd_pkg::WORD_W-1:0]         weight_nibbles_lo,
  input  logic [bsd_pkg::WORD_W-1:0]         weight_nibbles_hi,
  input  logic [bsd_pkg::SCALE_W-1:0]        act_scale,
  input  logic [bsd_pkg::SCALE_W-1:0]        weight_scale,
  input  logic                               last_block,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bsd_pkg::SUM_W-1:0]   scaled_sum,
  output logic                               overflowed
);
  import bsd_pkg::*;

  localparam int LANE_ACT_W = LANE_ELEMS * ACT_W;
  localparam int LANE_WT_W  = LANE_ELEMS * WT_W;

  logic adv;

  logic [LANES*LANE_ACT_W-1:0] act_all;
  logic [LANES*LANE_WT_W-1:0]  wt_all;

  stage_ctl_t               ctl_l, ctl_d, ctl_t;
  logic [SCALE_W-1:0]       as_l, ws_l, as_d, ws_d;
  logic signed [PART_W-1:0] partial [LANES];
  logic signed [DOT_W-1:0]  dot;
  logic signed [DOT_W-1:0]  dot_next;
  logic signed [TERM_W-1:0] term;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign act_all = {act_bytes_3, act_bytes_2, act_bytes_1, act_bytes_0};
  assign wt_all  = {weight_nibbles_hi, weight_nibbles_lo};

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    bsd_lane u_lane (
      .clk      (clk),
      .adv      (adv),
      .act_word (act_all[l*LANE_ACT_W +: LANE_ACT_W]),
      .wt_word  (wt_all[l*LANE_WT_W +: LANE_WT_W]),
      .elem_en  (elem_enable(LANE_IDX_W'(l))),
      .partial  (partial[l])
    );
  end

  always_comb begin
    dot_next = '0;
    for (int l = 0; l < LANES; l++) begin
      dot_next = dot_next + DOT_W'(partial[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_l <= '0;
      ctl_d <= '0;
    end else if (adv) begin
      ctl_l.valid <= in_valid;
      ctl_l.last  <= last_block;
      ctl_d       <= ctl_l;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      as_l <= act_scale;
      ws_l <= weight_scale;
      as_d <= as_l;
      ws_d <= ws_l;
      dot  <= dot_next;
    end
  end

  bsd_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .ctl_in       (ctl_d),
    .dot          (dot),
    .act_scale    (as_d),
    .weight_scale (ws_d),
    .ctl_out      (ctl_t),
    .term         (term)
  );

  bsd_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .ctl        (ctl_t),
    .term       (term),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .scaled_sum (scaled_sum),
    .overflowed (overflowed)
  );

endmodule

@@ tb/int4_int8_block_scaled_dot_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// int4_int8_block_scaled_dot_tb: self-checking bench for the block-scaled dot
// A directed table and then random chains of blocks are sent in. Each block is
// folded into a shadow saturating accumulator. Every result beat is compared
// against the oldest predicted sum, while both sides idle and stall at random.
// ============================================================================
module int4_int8_block_scaled_dot_tb;

  localparam int AW          = bsd_pkg::ACC_WIDTH;
  localparam int RANDOM_BEATS = 600;
  localparam int HOLD_AT_BEAT = 40;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_ROWS     = 23;
  localparam int RUN_REPS     = 8;

  localparam logic [63:0] A_ONES = {8{8'h01}};
  localparam logic [63:0] A_MIN  = {8{8'h80}};
  localparam logic [63:0] A_MAX  = {8{8'h7f}};
  localparam logic [63:0] W_ONES = {16{4'h1}};
  localparam logic [63:0] W_MIN  = {16{4'h8}};
  localparam logic [63:0] W_MAX  = {16{4'h7}};
  localparam logic [63:0] ZW     = 64'h0;
  localparam logic [15:0] S_FULL = 16'hffff;

  localparam logic signed [65:0] ACC_HI = (66'sd1 <<< (AW - 1)) - 66'sd1;
  localparam logic signed [65:0] ACC_LO = -ACC_HI - 66'sd1;

  typedef struct packed {
    logic [63:0] act0;
    logic [63:0] act1;
    logic [63:0] act2;
    logic [63:0] act3;
    logic [63:0] wt_lo;
    logic [63:0] wt_hi;
    logic [15:0] a_scale;
    logic [15:0] w_scale;
    logic        last;
  } block_t;

  typedef struct packed {
    logic signed [63:0] sum;
    logic               ovf;
  } sum_result_t;

  typedef struct packed {
    logic [31:0]        reps;
    block_t             blk;
    logic               known;
    logic signed [63:0] known_sum;
    logic               known_ovf;
  } plan_row_t;

  // Rows with known set carry a sum that can be read off by hand; the others
  // go through the shadow accumulator. A repeated row raises last only on its
  // final copy.
  localparam plan_row_t PLAN [NUM_ROWS] = '{
    '{32'd1, '{ZW, ZW, ZW, ZW, ZW, ZW, 16'h0, 16'h0, 1'b1}, 1'b1, 64'sd0, 1'b0},
    '{32'd1, '{A_ONES, A_ONES, A_ONES, A_ONES, W_ONES, W_ONES, 16'h1, 16'h1, 1'b1},
      1'b1, 64'sd32, 1'b0},
    '{32'd1, '{A_ONES, A_ONES, A_ONES, A_ONES, W_ONES, W_ONES, 16'h8000, 16'h8000, 1'b1},
      1'b1, 64'sh0000_0008_0000_0000, 1'b0},
    '{32'd1, '{A_MIN, A_MIN, A_MIN, A_MIN, W_MIN, W_MIN, S_FULL, S_FULL, 1'b1},
      1'b1, 64'sh0000_7fff_0000_8000, 1'b0},
    '{32'd1, '{A_MAX, A_MAX, A_MAX, A_MAX, W_MIN, W_MIN, S_FULL, S_FULL, 1'b1},
      1'b0, 64'sd0, 1'b0},
    '{32'd1, '{A_MIN, A_MIN, A_MIN, A_MIN, W_MAX, W_MAX, S_FULL, S_FULL, 1'b1},
      1'b0, 64'sd0, 1'b0},
    '{32'd1, '{A_MAX, A_MAX, A_MAX, A_MAX, W_MAX, W_MAX, S_FULL, S_FULL, 1'b1},
      1'b0, 64'sd0, 1'b0},
    '{32'd1, '{A_MIN, A_MIN, A_MIN, A_MIN, W_MIN, W_MIN, 16'h0, 16'h0, 1'b1},
      1'b1, 64'sd0, 1'b0},
    '{32'd1, '{A_MIN, A_MIN, A_MIN, A_MIN, W_MIN, W_MIN, S_FULL, 16'h0, 1'b1},
      1'b1, 64'sd0, 1'b0},
    '{32'd1, '{A_MIN, A_MIN, A_MIN, A_MIN, W_MIN, W_MIN, 16'h0, S_FULL, 1'b1},
      1'b1, 64'sd0, 1'b0},
    '{32'd3, '{A_ONES, A_ONES, A_ONES, A_ONES, W_ONES, W_ONES, 16'h1, 16'h1, 1'b1},
      1'b1, 64'sd96, 1'b0},
    // Single elements at the lane edges check byte order and nibble sign.
    '{32'd1, '{64'hff, ZW, ZW, ZW, 64'hf, ZW, 16'h1, 16'h1, 1'b1},
      1'b1, 64'sd1, 1'b0},
    '{32'd1, '{ZW, ZW, ZW, 64'h8000_0000_0000_0000, ZW, 64'h7000_0000_0000_0000,
               16'h1, 16'h1, 1'b1}, 1'b1, -64'sd896, 1'b0},
    '{32'd1, '{ZW, ZW, 64'h7f, ZW, ZW, 64'h8, 16'h1, 16'h1, 1'b1},
      1'b1, -64'sd1016, 1'b0},
    '{32'd1, '{ZW, 64'h7f00_0000_0000_0080, ZW, ZW, 64'h7000_0008_0000_0000, ZW,
               16'h1, 16'h1, 1'b1}, 1'b1, 64'sd1913, 1'b0},
    '{32'd1, '{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
               64'h5a5a_a5a5_0ff0_f00f, 64'h8001_7ffe_c33c_3cc3,
               64'h9e37_79b9_7f4a_7c15, 64'hf39c_c060_5cad_a5a1,
               16'h1234, 16'hfedc, 1'b0}, 1'b0, 64'sd0, 1'b0},
    '{32'd1, '{64'hdead_beef_0bad_f00d, 64'h3c3c_c3c3_9669_6996,
               64'h8080_7f7f_0101_ffff, 64'h1357_9bdf_2468_ace0,
               64'h0f1e_2d3c_4b5a_6978, 64'h8796_a5b4_c3d2_e1f0,
               S_FULL, 16'h1, 1'b1}, 1'b0, 64'sd0, 1'b0},
    // Runs of the largest terms of either sign build up wide sums.
    '{RUN_REPS, '{A_MIN, A_MIN, A_MIN, A_MIN, W_MIN, W_MIN, S_FULL, S_FULL, 1'b1},
      1'b0, 64'sd0, 1'b0},
    '{RUN_REPS, '{A_MIN, A_MIN, A_MIN, A_MIN, W_MIN, W_MIN, S_FULL, S_FULL, 1'b0},
      1'b0, 64'sd0, 1'b0},
    '{32'd10, '{A_MAX, A_MAX, A_MAX, A_MAX, W_MIN, W_MIN, S_FULL, S_FULL, 1'b1},
      1'b0, 64'sd0, 1'b0},
    '{RUN_REPS, '{A_MAX, A_MAX, A_MAX, A_MAX, W_MIN, W_MIN, S_FULL, S_FULL, 1'b1},
      1'b0, 64'sd0, 1'b0},
    '{32'd1, '{ZW, ZW, ZW, ZW, ZW, ZW, 16'h0, 16'h0, 1'b1}, 1'b1, 64'sd0, 1'b0},
    '{32'd1, '{A_MAX, A_MIN, A_ONES, ZW, W_MAX, W_MIN, 16'h0001, S_FULL, 1'b1},
      1'b0, 64'sd0, 1'b0}
  };

  logic        clk;
  logic        rst               = 1'b1;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [63:0] act_bytes_0       = '0;
  logic [63:0] act_bytes_1       = '0;
  logic [63:0] act_bytes_2       = '0;
  logic [63:0] act_bytes_3       = '0;
  logic [63:0] weight_nibbles_lo = '0;
  logic [63:0] weight_nibbles_hi = '0;
  logic [15:0] act_scale         = '0;
  logic [15:0] weight_scale      = '0;
  logic        last_block        = 1'b0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic signed [63:0] scaled_sum;
  logic        overflowed;

  // Hand-computed sum that rides along with the current input beat.
  logic               beat_known     = 1'b0;
  logic signed [63:0] beat_known_sum = '0;
  logic               beat_known_ovf = 1'b0;

  logic signed [AW-1:0] acc_shadow = '0;
  logic                 sat_shadow = 1'b0;
  sum_result_t          pending_sums[$];
  int                   mismatches = 0;
  bit                   send_calm  = 1'b0;
  bit                   recv_calm  = 1'b0;

  int4_int8_block_scaled_dot uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .act_bytes_0       (act_bytes_0),
    .act_bytes_1       (act_bytes_1),
    .act_bytes_2       (act_bytes_2),
    .act_bytes_3       (act_bytes_3),
    .weight_nibbles_lo (weight_nibbles_lo),
    .weight_nibbles_hi (weight_nibbles_hi),
    .act_scale         (act_scale),
    .weight_scale      (weight_scale),
    .last_block        (last_block),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .scaled_sum        (scaled_sum),
    .overflowed        (overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Adds one block into the shadow accumulator; returns 1 with the sum when
  // the block closes a dot product, and clears the shadow state then.
  function automatic bit fold_block(input block_t b, output sum_result_t res);
    logic [255:0]       acts;
    logic [127:0]       wts;
    longint signed      dot;
    longint signed      term;
    logic signed [65:0] wide;
    acts = {b.act3, b.act2, b.act1, b.act0};
    wts  = {b.wt_hi, b.wt_lo};
    dot  = 0;
    for (int i = 0; i < bsd_pkg::CARRIED_ELEMS && i < bsd_pkg::BLOCK_SIZE; i++) begin
      dot += longint'($signed(acts[8*i +: 8])) * longint'($signed(wts[4*i +: 4]));
    end
    term = dot * longint'(b.a_scale) * longint'(b.w_scale);
    if (bsd_pkg::SHL > 0) term = term <<< bsd_pkg::SHL;
    if (bsd_pkg::SHR > 0) term = term >>> bsd_pkg::SHR;
    wide = 66'(acc_shadow) + 66'(term);
    if (wide > ACC_HI) begin
      acc_shadow = ACC_HI[AW-1:0];
      sat_shadow = 1'b1;
    end else if (wide < ACC_LO) begin
      acc_shadow = ACC_LO[AW-1:0];
      sat_shadow = 1'b1;
    end else begin
      acc_shadow = wide[AW-1:0];
    end
    res = '{64'(acc_shadow), sat_shadow};
    if (!b.last) return 1'b0;
    acc_shadow = '0;
    sat_shadow = 1'b0;
    return 1'b1;
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  // Calm stretches draw no idle cycles at all.
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [63:0] pick_word(input logic [63:0] neg_fill,
                                            input logic [63:0] pos_fill);
    case ($urandom_range(0, 9))
      0: return neg_fill;
      1: return pos_fill;
      2: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return 16'h0;
      1: return S_FULL;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic offer_block(input block_t b, input int idle, input logic known,
                             input logic signed [63:0] known_sum, input logic known_ovf);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid          <= 1'b1;
    act_bytes_0       <= b.act0;
    act_bytes_1       <= b.act1;
    act_bytes_2       <= b.act2;
    act_bytes_3       <= b.act3;
    weight_nibbles_lo <= b.wt_lo;
    weight_nibbles_hi <= b.wt_hi;
    act_scale         <= b.a_scale;
    weight_scale      <= b.w_scale;
    last_block        <= b.last;
    beat_known        <= known;
    beat_known_sum    <= known_sum;
    beat_known_ovf    <= known_ovf;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin : monitor
    block_t      beat;
    sum_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        beat = '{act_bytes_0, act_bytes_1, act_bytes_2, act_bytes_3, weight_nibbles_lo,
                 weight_nibbles_hi, act_scale, weight_scale, last_block};
        if (fold_block(beat, want)) begin
          if (beat_known) want = '{beat_known_sum, beat_known_ovf};
          pending_sums.insert(pending_sums.size(), want);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_sums.size() == 0) begin
          log_mismatch($sformatf("result beat with none expected: sum %h overflowed %b",
                                 scaled_sum, overflowed));
        end else begin
          want = pending_sums.pop_front();
          if (scaled_sum !== want.sum)
            log_mismatch($sformatf("scaled_sum expected %h got %h", want.sum, scaled_sum));
          if (overflowed !== want.ovf)
            log_mismatch($sformatf("overflowed expected %b got %b", want.ovf, overflowed));
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so the pipeline backs up.
  initial begin : drain
    int gap;
    int beats;
    beats = 0;
    forever begin
      if (beats == HOLD_AT_BEAT) gap = LONG_HOLD;
      else gap = draw_gap(recv_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      beats++;
    end
  end

  initial begin : stimulus
    plan_row_t row;
    block_t    blk;
    int        chain;
    int        sent;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = PLAN[r];
      for (int k = 0; k < int'(row.reps); k++) begin
        blk      = row.blk;
        blk.last = row.blk.last && (k == int'(row.reps) - 1);
        offer_block(blk, draw_gap(send_calm), row.known, row.known_sum, row.known_ovf);
      end
    end

    // Mostly well-formed chains of one to eight blocks, with a stray last
    // flag now and then to break a chain early or run it on.
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      chain = $urandom_range(1, 8);
      for (int k = 0; k < chain; k++) begin
        blk.act0    = pick_word(A_MIN, A_MAX);
        blk.act1    = pick_word(A_MIN, A_MAX);
        blk.act2    = pick_word(A_MIN, A_MAX);
        blk.act3    = pick_word(A_MIN, A_MAX);
        blk.wt_lo   = pick_word(W_MIN, W_MAX);
        blk.wt_hi   = pick_word(W_MIN, W_MAX);
        blk.a_scale = pick_scale();
        blk.w_scale = pick_scale();
        if ($urandom_range(0, 11) == 0) blk.last = 1'($urandom_range(0, 1));
        else blk.last = (k == chain - 1);
        offer_block(blk, draw_gap(send_calm), 1'b0, '0, 1'b0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
